// ===== sv/xmcr_pkg.sv =====
// Shared types and constants for the XMODEM checksum receiver core.
// No dependencies; imported by xmodem_checksum_receiver_core.
package xmcr_pkg;

  // Default number of payload bytes in one block
  localparam int BLOCK_BYTES_DEF = 128;

  // Results a single input can cause, and depth of the result queue
  localparam int MAX_RES   = 3;
  localparam int OQ_DEPTH  = 4;

  // Line control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_PRE_BETA   = 3'd0;
  localparam logic [2:0] REG_MORE       = 3'd1;
  localparam logic [2:0] REG_RETRY      = 3'd2;
  localparam logic [2:0] REG_HDR_TMO    = 3'd3;
  localparam logic [2:0] REG_CHAR_TMO   = 3'd4;
  localparam logic [2:0] REG_RECORD_TMO = 3'd5;

  // Configuration reset values
  localparam logic [3:0]  RETRY_RST      = 4'd10;
  localparam logic [15:0] HDR_TMO_RST    = 16'd10000;
  localparam logic [15:0] CHAR_TMO_RST   = 16'd1000;
  localparam logic [15:0] RECORD_TMO_RST = 16'd10000;

  // Result kinds
  typedef enum logic [2:0] {
    K_SEND    = 3'd0,
    K_PAYLOAD = 3'd1,
    K_ACCEPT  = 3'd2,
    K_DISCARD = 3'd3,
    K_DONE    = 3'd4,
    K_ABORT   = 3'd5
  } kind_t;

  // Receiver phases, one-hot
  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_REC     = 7'b0000010,
    PH_RECBAR  = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_CKSUM   = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_ABORTED = 7'b1000000
  } phase_t;

  // One result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [6:0] offset;
    logic       last;
  } result_t;

endpackage

// ===== sv/xmodem_checksum_receiver_core.sv =====
// XMODEM receiver (8-bit checksum): block parser, result queue, config registers.
// Depends on xmcr_pkg.
// Results of an accepted beat are registered in the result queue, whose head drives the out_ channel.
// Throughput: one input beat per cycle and one result beat per cycle while out_stall is
// low; the input stalls while the 4-entry result queue has fewer than 3 free slots.
// Reset (rst_n low, synchronous): phase waits for block start, expected record 1,
// counters cleared, queue empty, configuration at its defaults.
module xmodem_checksum_receiver_core
  import xmcr_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_byte_value,
  output logic [6:0]  out_byte_offset,
  output logic        out_last,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W = (BLOCK_BYTES > 128) ? $clog2(BLOCK_BYTES) : 7;
  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam int OQC_W = $clog2(OQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BLOCK_BYTES - 1);

  // configuration registers
  logic        pre_beta_r;
  logic        more_r;
  logic [3:0]  retry_r;
  logic [15:0] hdr_tmo_r;
  logic [15:0] char_tmo_r;
  logic [15:0] record_tmo_r;

  // receiver state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       exp_rec_r, exp_rec_nxt;
  logic [7:0]       hdr_rec_r, hdr_rec_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [3:0]       nak_r, nak_nxt;
  logic [15:0]      timer_r, timer_nxt;

  // result queue
  result_t          oq_mem [OQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQC_W-1:0] oq_cnt_r;

  // per-beat results
  result_t    res [MAX_RES];
  logic [1:0] n_res;

  logic            in_fire, out_fire;
  logic            do_fail, do_abort;
  logic [15:0]     limit, timer_inc;
  logic [6:0]      cnt_ext;

  assign in_stall  = (oq_cnt_r > OQC_W'(OQ_DEPTH - MAX_RES));
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = (oq_cnt_r != '0);
  assign out_fire  = out_valid & ~out_stall;
  assign cfg_ready = 1'b1;
  assign cnt_ext   = cnt_r[6:0];

  // Present the queue head
  assign out_result_kind = oq_mem[rd_ptr_r].kind;
  assign out_byte_value  = oq_mem[rd_ptr_r].value;
  assign out_byte_offset = oq_mem[rd_ptr_r].offset;
  assign out_last        = oq_mem[rd_ptr_r].last;

  // Decode one beat: next state and up to three results
  always_comb begin
    phase_nxt   = phase_r;
    exp_rec_nxt = exp_rec_r;
    hdr_rec_nxt = hdr_rec_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    nak_nxt     = nak_r;
    timer_nxt   = timer_r;
    do_fail     = 1'b0;
    do_abort    = 1'b0;
    n_res       = 2'd0;
    limit       = hdr_tmo_r;
    timer_inc   = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '{kind: K_SEND, value: 8'h00, offset: 7'h00, last: 1'b0};
    end

    if (in_opcode == OP_TICK) begin
      // Count a tick and check the phase's timeout
      case (phase_r)
        PH_START:   limit = hdr_tmo_r;
        PH_PAYLOAD: limit = record_tmo_r;
        default:    limit = char_tmo_r;
      endcase
      if (phase_r != PH_DONE && phase_r != PH_ABORTED) begin
        timer_nxt = timer_inc;
        do_fail   = (timer_inc >= limit);
      end
    end else begin
      case (phase_r)
        PH_START: begin
          if (in_rx_byte == CH_SOH) begin
            phase_nxt = PH_REC;
            timer_nxt = '0;
          end else if (in_rx_byte == CH_EOT) begin
            if (!pre_beta_r) begin
              res[n_res] = '{kind: K_SEND, value: CH_ACK, offset: 7'h00, last: 1'b0};
              n_res      = n_res + 2'd1;
            end
            if (more_r) begin
              res[n_res] = '{kind: K_SEND, value: CH_NAK, offset: 7'h00, last: 1'b0};
              n_res      = n_res + 2'd1;
            end
            res[n_res] = '{kind: K_DONE, value: 8'h00, offset: 7'h00, last: 1'b0};
            n_res      = n_res + 2'd1;
            phase_nxt  = PH_DONE;
            timer_nxt  = '0;
          end else if (in_rx_byte == CH_CAN) begin
            do_abort = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_REC: begin
          hdr_rec_nxt = in_rx_byte;
          phase_nxt   = PH_RECBAR;
          timer_nxt   = '0;
        end
        PH_RECBAR: begin
          if (({1'b0, hdr_rec_r} + {1'b0, in_rx_byte}) != 9'd255) begin
            do_fail = 1'b1;
          end else begin
            cnt_nxt   = '0;
            sum_nxt   = '0;
            phase_nxt = PH_PAYLOAD;
            timer_nxt = '0;
          end
        end
        PH_PAYLOAD: begin
          // Emit the byte and fold it into the checksum
          res[0]  = '{kind: K_PAYLOAD, value: in_rx_byte, offset: cnt_ext, last: 1'b0};
          n_res   = 2'd1;
          sum_nxt = sum_r + in_rx_byte;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LAST_POS) begin
            phase_nxt = PH_CKSUM;
            timer_nxt = '0;
          end
        end
        PH_CKSUM: begin
          if (in_rx_byte != sum_r) begin
            do_fail = 1'b1;
          end else if (hdr_rec_r == exp_rec_r) begin
            res[0]      = '{kind: K_ACCEPT, value: 8'h00, offset: 7'h00, last: 1'b0};
            res[1]      = '{kind: K_SEND, value: CH_ACK, offset: 7'h00, last: 1'b0};
            n_res       = 2'd2;
            exp_rec_nxt = exp_rec_r + 8'd1;
            nak_nxt     = '0;
            phase_nxt   = PH_START;
            timer_nxt   = '0;
          end else if (hdr_rec_r == exp_rec_r - 8'd1) begin
            res[0]    = '{kind: K_DISCARD, value: 8'h00, offset: 7'h00, last: 1'b0};
            res[1]    = '{kind: K_SEND, value: CH_ACK, offset: 7'h00, last: 1'b0};
            n_res     = 2'd2;
            nak_nxt   = '0;
            phase_nxt = PH_START;
            timer_nxt = '0;
          end else begin
            do_abort = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Failed block: NAK and retry, or give up
    if (do_fail) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      if (nak_r < retry_r) begin
        nak_nxt   = nak_r + 4'd1;
        res[0]    = '{kind: K_DISCARD, value: 8'h00, offset: 7'h00, last: 1'b0};
        res[1]    = '{kind: K_SEND, value: CH_NAK, offset: 7'h00, last: 1'b0};
        n_res     = 2'd2;
        phase_nxt = PH_START;
        timer_nxt = '0;
      end else begin
        do_abort = 1'b1;
      end
    end

    // Abort: send CAN and stop
    if (do_abort) begin
      res[0]    = '{kind: K_SEND, value: CH_CAN, offset: 7'h00, last: 1'b0};
      res[1]    = '{kind: K_ABORT, value: 8'h00, offset: 7'h00, last: 1'b0};
      n_res     = 2'd2;
      phase_nxt = PH_ABORTED;
      timer_nxt = '0;
    end

    // Mark the final result of this beat
    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last = 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_beta_r   <= 1'b0;
      more_r       <= 1'b0;
      retry_r      <= RETRY_RST;
      hdr_tmo_r    <= HDR_TMO_RST;
      char_tmo_r   <= CHAR_TMO_RST;
      record_tmo_r <= RECORD_TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRE_BETA:   pre_beta_r   <= cfg_data[0];
        REG_MORE:       more_r       <= cfg_data[0];
        REG_RETRY:      retry_r      <= cfg_data[3:0];
        REG_HDR_TMO:    hdr_tmo_r    <= cfg_data;
        REG_CHAR_TMO:   char_tmo_r   <= cfg_data;
        REG_RECORD_TMO: record_tmo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Receiver state: advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      exp_rec_r <= 8'd1;
      hdr_rec_r <= 8'd0;
      cnt_r     <= '0;
      sum_r     <= 8'd0;
      nak_r     <= 4'd0;
      timer_r   <= 16'd0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      exp_rec_r <= exp_rec_nxt;
      hdr_rec_r <= hdr_rec_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      nak_r     <= nak_nxt;
      timer_r   <= timer_nxt;
    end
  end

  // Result queue storage: push up to three entries per beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < n_res) begin
          oq_mem[wr_ptr_r + PTR_W'(k)] <= res[k];
        end
      end
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      oq_cnt_r <= oq_cnt_r + (in_fire ? OQC_W'(n_res) : OQC_W'(0))
                           - (out_fire ? OQC_W'(1) : OQC_W'(0));
    end
  end

endmodule
